// File: rtl/b2bpow_pkg.sv
//------------------------------------------------------------------------------
// b2bpow_pkg
// Shared types and constants for the BLAKE2b proof-of-work nonce search.
//------------------------------------------------------------------------------
package b2bpow_pkg;

   localparam logic [63:0] ThresholdReset = 64'hFFFF_FE00_0000_0000;
   localparam int unsigned RoundCount = 12;

   localparam logic [0:0] CsrThreshold = 1'b0;
   localparam logic [0:0] CsrAttemptLimit = 1'b1;

   // Initialization vector.
   function automatic logic [63:0] iv_word(input logic [2:0] idx);
      logic [63:0] r;
      begin
         case (idx)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            3'd7: r = 64'h5be0cd19137e2179;
            default: r = '0;
         endcase
         return r;
      end
   endfunction

   // Message schedule: word index for round and slot.
   function automatic logic [3:0] sigma(input logic [3:0] rnd, input logic [3:0] slot);
      logic [63:0] row;
      logic [3:0] r10;
      begin
         r10 = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
         case (r10)
            4'd0: row = 64'hFEDCBA9876543210;
            4'd1: row = 64'h357B20C16DF984AE;
            4'd2: row = 64'h491763EADF250C8B;
            4'd3: row = 64'h8F04A562EBCD1397;
            4'd4: row = 64'hD386CB1EFA427509;
            4'd5: row = 64'h91EF57D438B0A6C2;
            4'd6: row = 64'hB8293670A4DEF15C;
            4'd7: row = 64'hA2684F05931CE7BD;
            4'd8: row = 64'h5A417D2C803B9EF6;
            4'd9: row = 64'h0DC3E9BF5167482A;
            default: row = '0;
         endcase
         return row[slot*4 +: 4];
      end
   endfunction

   typedef struct packed {
      logic load;
      logic step;
      logic next_nonce;
   } b2bpow_cmd_type;

   typedef struct packed {
      logic hit;
      logic [63:0] value;
   } b2bpow_stat_type;

endpackage

// File: rtl/b2bpow_datapath.sv
//------------------------------------------------------------------------------
// b2bpow_datapath
// Working vector, message words and one G mix per cycle.
//------------------------------------------------------------------------------
module b2bpow_datapath
   import b2bpow_pkg::*;
(
   input  logic            clock,
   input  b2bpow_cmd_type  cmd,
   input  logic [3:0]      rnd,
   input  logic [2:0]      mix_sel,
   input  logic [255:0]    root_in,
   input  logic [63:0]     nonce_in,
   input  logic [63:0]     threshold,
   output logic [63:0]     nonce,
   output b2bpow_stat_type stat
);

   localparam logic [63:0] H0 = 64'h6a09e667f3bcc908 ^ 64'h0101_0008;

   logic [63:0] v_ff [16];
   logic [63:0] v_in [16];
   logic [255:0] root_ff;
   logic [63:0] nonce_ff;
   logic [63:0] nonce_in_w;
   logic [3:0] ia, ib, ic, id;
   logic [63:0] a, b, c, d, x, y;
   logic [3:0] sx, sy;

   function automatic logic [63:0] msg(input logic [3:0] k, input logic [63:0] n,
                                       input logic [255:0] r);
      logic [63:0] w;
      begin
         case (k)
            4'd0: w = n;
            4'd1: w = r[63:0];
            4'd2: w = r[127:64];
            4'd3: w = r[191:128];
            4'd4: w = r[255:192];
            default: w = '0;
         endcase
         return w;
      end
   endfunction

   always_comb begin
      case (mix_sel)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
      sx = sigma(rnd, {mix_sel, 1'b0});
      sy = sigma(rnd, {mix_sel, 1'b1});
      x = msg(sx, nonce_ff, root_ff);
      y = msg(sy, nonce_ff, root_ff);
      a = v_ff[ia] + v_ff[ib] + x;
      d = v_ff[id] ^ a; d = {d[31:0], d[63:32]};
      c = v_ff[ic] + d;
      b = v_ff[ib] ^ c; b = {b[23:0], b[63:24]};
      a = a + b + y;
      d = d ^ a; d = {d[15:0], d[63:16]};
      c = c + d;
      b = b ^ c; b = {b[62:0], b[63]};
      v_in = v_ff;
      if (cmd.load) begin
         v_in[0] = H0;
         for (int i = 1; i < 8; i++) v_in[i] = iv_word(3'(i));
         for (int i = 0; i < 8; i++) v_in[8 + i] = iv_word(3'(i));
         v_in[12] = iv_word(3'd4) ^ 64'd40;
         v_in[14] = ~iv_word(3'd6);
      end else if (cmd.step) begin
         v_in[ia] = a; v_in[ib] = b; v_in[ic] = c; v_in[id] = d;
      end
      nonce_in_w = nonce_ff;
      if (cmd.next_nonce) nonce_in_w = nonce_ff + 64'd1;
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
      if (cmd.step && cmd.load) begin
         root_ff <= root_in;
         nonce_ff <= nonce_in;
      end else begin
         nonce_ff <= nonce_in_w;
      end
   end

   assign nonce = nonce_ff;
   assign stat.value = H0 ^ v_ff[0] ^ v_ff[8];
   assign stat.hit = stat.value > threshold;

endmodule

// File: rtl/b2bpow_ctrl.sv
//------------------------------------------------------------------------------
// b2bpow_ctrl
// Sequencer: load, 96 mix steps per attempt, check, next nonce or report.
//------------------------------------------------------------------------------
module b2bpow_ctrl
   import b2bpow_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  logic            rsp_stall,
   input  logic [31:0]     attempt_limit,
   input  logic [63:0]     threshold,
   input  b2bpow_stat_type stat,
   output b2bpow_cmd_type  cmd,
   output logic [3:0]      rnd,
   output logic [2:0]      mix_sel,
   output logic            done,
   output logic            found
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_INIT = 4'b0010,
      ST_MIX  = 4'b0100,
      ST_TEST = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [2:0] mix_ff, mix_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [63:0] total_ff, total_in;

   always_comb begin
      state_in = state_ff; rnd_in = rnd_ff; mix_in = mix_ff;
      cnt_in = cnt_ff; total_in = total_ff;
      cmd = '0; done = 1'b0; found = stat.hit;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1; cmd.step = 1'b1;
               cnt_in = '0; total_in = '0; state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.load = 1'b1; rnd_in = '0; mix_in = '0; state_in = ST_MIX;
         end
         ST_MIX: begin
            cmd.step = 1'b1;
            mix_in = mix_ff + 3'd1;
            if (mix_ff == 3'd7) begin
               if (rnd_ff == 4'(RoundCount - 1)) begin
                  state_in = ST_TEST;
                  cnt_in = cnt_ff + 32'd1; total_in = total_ff + 64'd1;
               end else begin
                  rnd_in = rnd_ff + 4'd1;
               end
            end
         end
         ST_TEST: begin
            if (stat.hit || threshold == '1 ||
                (attempt_limit != '0 && cnt_ff == attempt_limit) || total_ff == '0) begin
               // A result still waiting at the output keeps the engine here.
               if (!rsp_stall) begin
                  done = 1'b1; state_in = ST_IDLE;
               end
            end else begin
               cmd.next_nonce = 1'b1; state_in = ST_INIT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; rnd_ff <= '0; mix_ff <= '0;
         cnt_ff <= '0; total_ff <= '0;
      end else begin
         state_ff <= state_in; rnd_ff <= rnd_in; mix_ff <= mix_in;
         cnt_ff <= cnt_in; total_ff <= total_in;
      end
   end

   assign busy = state_ff != ST_IDLE;
   assign rnd = rnd_ff;
   assign mix_sel = mix_ff;

endmodule

// File: rtl/blake2b_work_nonce_search_top.sv
//------------------------------------------------------------------------------
// blake2b_work_nonce_search_top
// BLAKE2b-64 proof-of-work nonce search engine.
//------------------------------------------------------------------------------
// Usage: one req beat carries the 32-byte root and a start nonce and starts
// a search. Each attempt runs one BLAKE2b compression of twelve rounds with
// one G mix per cycle: a load step, 96 mix steps and a test step per nonce
// tried. The search ends on the first digest above the threshold, at a
// nonzero attempt limit, after 2^64 attempts, or when the threshold is all ones.
// One rsp beat then carries nonce, digest value and the found flag.
// A new req beat is taken while the result waits in the output register; if
// the next search finishes before that result is taken, the engine holds in
// its test step and req_tready stays low until rsp_tready frees the register.
// Reset idles the engine, empties the output register and restores the
// threshold and attempt limit defaults. Configuration must be written
// through csr_ only while no search is running; the block itself does not
// enforce this.
//------------------------------------------------------------------------------
module blake2b_work_nonce_search_top
   import b2bpow_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // root_word0, root_word1, root_word2, root_word3, start_nonce
   input  logic [319:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // work_nonce, work_value, found, zero fill
   output logic [135:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [0:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   logic [63:0] threshold_ff;
   logic [31:0] limit_ff;
   logic busy, done, found, rsp_valid_ff;
   logic [128:0] rsp_ff;
   b2bpow_cmd_type cmd;
   b2bpow_stat_type stat;
   logic [3:0] rnd;
   logic [2:0] mix_sel;
   logic [63:0] nonce;
   logic start;
   logic rsp_stall;

   assign req_tready = !busy;
   assign start = req_tvalid && req_tready;
   assign rsp_stall = rsp_valid_ff && !rsp_tready;

   b2bpow_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .rsp_stall, .attempt_limit(limit_ff),
      .threshold(threshold_ff), .stat, .cmd, .rnd, .mix_sel, .done, .found
   );

   b2bpow_datapath u_dp (
      .clock, .cmd, .rnd, .mix_sel, .root_in(req_tdata[255:0]),
      .nonce_in(req_tdata[319:256]), .threshold(threshold_ff), .nonce, .stat
   );

   // CSR and output registers; a result still held stalls the test step until the output register frees.
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= ThresholdReset;
         limit_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == CsrThreshold) threshold_ff <= csr_wdata;
         if (csr_we && csr_index == CsrAttemptLimit) limit_ff <= csr_wdata[31:0];
         if (done) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= {found, stat.value, nonce};
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_ff};

endmodule

// File: tb/tb_blake2b_work_nonce_search_top.sv
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// tb_blake2b_work_nonce_search_top
// Drives search requests over the req stream and writes threshold and attempt
// limit between phases. Each rsp beat is checked against an in-bench BLAKE2b
// nonce search. Both stream sides idle at random, with one long receiver
// hold-off that fills the engine up.
//------------------------------------------------------------------------------
module tb_blake2b_work_nonce_search_top
   import b2bpow_pkg::*;
();

   localparam int unsigned WatchdogLimit = 20000;
   localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [63:0] nonce;
      logic [63:0] value;
      logic        found;
   } search_result_type;

   typedef struct {
      logic [63:0] thr;
      logic [63:0] lim;
      logic [63:0] root0, root1, root2, root3;
      logic [63:0] start;
      bit          known;
      logic        exp_found;
      logic [63:0] exp_nonce;
   } stim_row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [135:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [0:0]   csr_index = CsrThreshold;
   logic [63:0]  csr_wdata = '0;

   search_result_type result_q[$];
   int unsigned    errors = 0;
   int unsigned    idle_cycles = 0;
   bit             hold_req = 1'b0;
   int unsigned    hold_left = 0;
   logic [63:0]    cur_thr = ThresholdReset;
   logic [31:0]    cur_lim = '0;

   // Message word index per round and slot.
   byte unsigned msg_sched[10][16] = '{
      '{ 0, 1, 2, 3, 4, 5, 6, 7, 8, 9,10,11,12,13,14,15},
      '{14,10, 4, 8, 9,15,13, 6, 1,12, 0, 2,11, 7, 5, 3},
      '{11, 8,12, 0, 5, 2,15,13,10,14, 3, 6, 7, 1, 9, 4},
      '{ 7, 9, 3, 1,13,12,11,14, 2, 6, 5,10, 4, 0,15, 8},
      '{ 9, 0, 5, 7, 2, 4,10,15,14, 1,11,12, 6, 8, 3,13},
      '{ 2,12, 6,10, 0,11, 8, 3, 4,13, 7, 5,15,14, 1, 9},
      '{12, 5, 1,15,14,13, 4,10, 0, 7, 6, 3, 9, 2, 8,11},
      '{13,11, 7,14,12, 1, 3, 9, 5, 0,15, 4, 8, 6, 2,10},
      '{ 6,15,14, 9,11, 3, 0, 8,12, 2,13, 7, 1, 4,10, 5},
      '{10, 2, 8, 4, 7, 6, 1, 5,15,11, 9,14, 3,12,13, 0}};
   logic [63:0] chain_iv[8] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
      64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
      64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
   byte unsigned mix_a[8] = '{0, 1, 2, 3, 0, 1, 2, 3};
   byte unsigned mix_b[8] = '{4, 5, 6, 7, 5, 6, 7, 4};
   byte unsigned mix_c[8] = '{8, 9, 10, 11, 10, 11, 8, 9};
   byte unsigned mix_d[8] = '{12, 13, 14, 15, 15, 12, 13, 14};

   function automatic logic [63:0] rotr64(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] work_digest(logic [63:0] root[4], logic [63:0] nonce);
      logic [63:0] m[16];
      logic [63:0] v[16];
      logic [63:0] h0;
      int a, b, c, d;
      h0 = chain_iv[0] ^ 64'h0101_0008;
      for (int i = 0; i < 16; i++) m[i] = '0;
      m[0] = nonce;
      for (int i = 0; i < 4; i++) m[1 + i] = root[i];
      for (int i = 0; i < 8; i++) begin
         v[i] = chain_iv[i];
         v[8 + i] = chain_iv[i];
      end
      v[0] = h0;
      v[12] ^= 64'd40;
      v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         for (int j = 0; j < 8; j++) begin
            a = mix_a[j]; b = mix_b[j]; c = mix_c[j]; d = mix_d[j];
            v[a] = v[a] + v[b] + m[msg_sched[r % 10][2 * j]];
            v[d] = rotr64(v[d] ^ v[a], 32);
            v[c] = v[c] + v[d];
            v[b] = rotr64(v[b] ^ v[c], 24);
            v[a] = v[a] + v[b] + m[msg_sched[r % 10][2 * j + 1]];
            v[d] = rotr64(v[d] ^ v[a], 16);
            v[c] = v[c] + v[d];
            v[b] = rotr64(v[b] ^ v[c], 63);
         end
      end
      return h0 ^ v[0] ^ v[8];
   endfunction

   function automatic search_result_type nonce_search(logic [319:0] data);
      logic [63:0] root[4];
      logic [63:0] nonce;
      logic [63:0] total;
      logic [31:0] tries;
      search_result_type res;
      for (int i = 0; i < 4; i++) root[i] = data[64 * i +: 64];
      nonce = data[319:256];
      tries = '0;
      total = '0;
      res.found = 1'b0;
      forever begin
         res.value = work_digest(root, nonce);
         tries++;
         total++;
         if (res.value > cur_thr) begin
            res.found = 1'b1;
            break;
         end
         if (cur_thr == AllOnes) break;
         if (cur_lim != 0 && tries == cur_lim) break;
         if (total == 0) break;
         nonce++;
      end
      res.nonce = nonce;
      return res;
   endfunction

   always #6 clock = ~clock;

   // Receiver: random ready, with a long hold-off on request.
   always @(posedge clock) begin
      if (hold_req && hold_left == 0) begin
         hold_left <= 600;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= (hold_left == 1);
      end else if ($urandom_range(0, 99) < 5) begin
         hold_left <= $urandom_range(15, 60);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Result checker.
   always @(posedge clock) begin
      search_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (result_q.size() == 0) begin
            $display("%0t: unexpected rsp beat %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = result_q.pop_front();
            if (rsp_tdata[63:0] !== want.nonce) begin
               $display("%0t: work_nonce expected %h actual %h", $time, want.nonce,
                        rsp_tdata[63:0]);
               errors++;
            end
            if (rsp_tdata[127:64] !== want.value) begin
               $display("%0t: work_value expected %h actual %h", $time, want.value,
                        rsp_tdata[127:64]);
               errors++;
            end
            if (rsp_tdata[128] !== want.found) begin
               $display("%0t: found expected %b actual %b", $time, want.found,
                        rsp_tdata[128]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb_blake2b_work_nonce_search_top NOT OK");
         $finish;
      end
   end

   blake2b_work_nonce_search_top u_dut (.*);

   // The sender stops offering and waits until every result is back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (result_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limits(logic [63:0] thr, logic [63:0] lim);
      drain();
      csr_we <= 1'b1;
      csr_index <= CsrThreshold;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CsrAttemptLimit;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_thr = thr;
      cur_lim = lim[31:0];
   endtask

   task automatic send_search(logic [319:0] data, output search_result_type want);
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(20, 80)) @(posedge clock);
      end else if (pick < 40) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      do @(posedge clock); while (!req_tready);
      want = nonce_search(data);
      result_q.push_back(want);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   initial begin
      stim_row_type rows[$];
      stim_row_type row;
      search_result_type want;
      logic [63:0] thr, lim;
      int unsigned mode;
      rows = '{
         '{ThresholdReset, 64'd2, 0, 0, 0, 0, 0, 0, 1'b0, 0},
         '{AllOnes, 64'd0, 0, 0, 0, 0, 0, 1, 1'b0, 0},
         '{AllOnes, 64'd0, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, 1, 1'b0, AllOnes},
         '{64'd0, 64'd0, AllOnes, AllOnes, AllOnes, AllOnes, AllOnes, 0, 1'b0, 0},
         '{64'd0, 64'd1, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
           64'h5555_aaaa_5555_aaaa, 64'haaaa_5555_aaaa_5555, 64'd7, 0, 1'b0, 0},
         '{ThresholdReset, 64'd1, 64'd1, 64'd2, 64'd3, 64'd4, AllOnes, 0, 1'b0, 0},
         '{ThresholdReset, 64'hFFFF_FFFF_0000_0003, AllOnes, 0, AllOnes, 0,
           AllOnes - 1, 0, 1'b0, 0},
         '{ThresholdReset, 64'd4, 0, AllOnes, 0, AllOnes, 64'h8000_0000_0000_0000,
           0, 1'b0, 0},
         '{64'h7FFF_FFFF_FFFF_FFFF, 64'd0, 64'd9, 64'd8, 64'd7, 64'd6, 64'd5, 0, 1'b0, 0},
         '{64'd0, 64'hFFFF_FFFF, 64'd11, 64'd22, 64'd33, 64'd44, 64'd55, 0, 1'b0, 0},
         '{AllOnes, 64'hFFFF_FFFF, 64'd1, 64'd1, 64'd1, 64'd1, 64'd99, 1, 1'b0, 64'd99},
         '{64'hFFFF_FFFF_FFFF_FFFE, 64'd1, 64'd3, 64'd3, 64'd3, 64'd3, 64'd3, 0, 1'b0, 0}};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         row = rows[i];
         // The first row leaves the threshold at its reset value.
         if (i == 0) begin
            csr_we <= 1'b1;
            csr_index <= CsrAttemptLimit;
            csr_wdata <= row.lim;
            @(posedge clock);
            csr_we <= 1'b0;
            cur_lim = row.lim[31:0];
         end else if (row.thr != cur_thr || row.lim[31:0] != cur_lim) begin
            write_limits(row.thr, row.lim);
         end
         send_search({row.start, row.root3, row.root2, row.root1, row.root0}, want);
         if (row.known && (want.found !== row.exp_found || want.nonce !== row.exp_nonce)) begin
            $display("%0t: table row %0d expected %b/%h, search gives %b/%h", $time, i,
                     row.exp_found, row.exp_nonce, want.found, want.nonce);
            errors++;
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         mode = (ph < 6) ? ph : $urandom_range(0, 5);
         case (mode)
            0: begin thr = 64'd0; lim = 64'd0; end
            1: begin thr = rand64() >> 1; lim = {rand64() & 64'hFFFF_FFFF_0000_0000}; end
            2: begin thr = ThresholdReset; lim = {$urandom, 32'($urandom_range(1, 3))}; end
            3: begin thr = AllOnes; lim = rand64(); end
            4: begin thr = rand64(); lim = {$urandom, 32'($urandom_range(1, 4))}; end
            default: begin thr = rand64() >> 2; lim = {32'h0, 32'hFFFF_FFFF}; end
         endcase
         write_limits(thr, lim);
         for (int n = 0; n < 13; n++) begin
            if (ph == 2 && n == 1) hold_req <= 1'b1;
            if (ph == 2 && n == 2) hold_req <= 1'b0;
            send_search({rand64(), rand64(), rand64(), rand64(), rand64()}, want);
            if (n == 6) begin
               // Sender pauses until every result is back.
               drain();
            end
         end
      end

      drain();
      if (errors == 0)
         $display("tb_blake2b_work_nonce_search_top OK");
      else
         $display("tb_blake2b_work_nonce_search_top NOT OK");
      $finish;
   end

endmodule
